@@ hdl/frkc_pkg.sv @@
`timescale 1ns / 1ps

package frkc_pkg;

  // Width of the capacity register and its value after reset.
  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  // Fixed widths of the result fields.
  localparam int OUT_KEY_W = 32;
  localparam int COUNT_OUT_W = 6;

  // Control half of a queue entry as seen by the back part.
  typedef struct packed {
    logic valid;
    logic eos;
  } frkc_ctl_t;

endpackage

@@ hdl/frkc_in_queue.sv @@
`timescale 1ns / 1ps

module frkc_in_queue
  import frkc_pkg::*;
#(
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic                in_end_of_sequence,
  output frkc_ctl_t           q_ctl,
  output logic [KEY_BITS-1:0] q_key,
  input  logic                q_pop
);

  // Two-entry queue; the payload is stored without reset.
  logic [KEY_BITS-1:0] key_r [2];
  logic                eos_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          count_r, count_nxt;
  logic                push;
  logic                pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count_r != 2'd0);

  // Head of the queue as presented to the back part.
  assign q_ctl.valid = (count_r != 2'd0);
  assign q_ctl.eos   = eos_r[rd_ptr_r];
  assign q_key       = key_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Accepted beats are written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      key_r[wr_ptr_r] <= in_key;
      eos_r[wr_ptr_r] <= in_end_of_sequence;
    end
  end

endmodule

@@ hdl/frkc_store.sv @@
`timescale 1ns / 1ps

module frkc_store
  import frkc_pkg::*;
#(
  parameter int MAX_SLOTS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CFG_W-1:0]       capacity,
  input  frkc_ctl_t              q_ctl,
  input  logic [KEY_BITS-1:0]    q_key,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_KEY_W-1:0]   out_stored_key,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic                   out_last_entry
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int SW    = IDX_W + 2;
  localparam int CW    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam logic [SW-1:0]    MAX_S   = SW'(MAX_SLOTS);
  localparam logic [CW-1:0]    MAX_C   = CW'(MAX_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(MAX_SLOTS - 1);

  // Ring of key slots with a valid bit each.
  logic [KEY_BITS-1:0]  slot_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]     old_r, old_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // Dump sequencer.
  logic [IDX_W-1:0]     dump_pos_r, dump_pos_nxt;
  logic [CNT_W-1:0]     remain_r, remain_nxt;
  logic [CNT_W-1:0]     dump_n_r, dump_n_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0]   out_key_r, out_key_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [MAX_SLOTS-1:0] hit_vec;
  logic                 miss;
  logic                 evict;
  logic                 take;
  logic                 load_out;
  logic [CW-1:0]        cap_eff;
  logic [CNT_W-1:0]     cnt_keep;
  logic [CNT_W-1:0]     cnt_new;
  logic [IDX_W-1:0]     old_new;
  logic [IDX_W-1:0]     ins_pos;
  logic [IDX_W-1:0]     newest;

  // Sum of a ring index and an offset below twice the ring size, wrapped.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + b;
    if (s >= MAX_S) begin
      s = s - MAX_S;
    end
    return s[IDX_W-1:0];
  endfunction

  // Parallel compare against every valid slot.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (slot_r[i] == q_key);
    end
  end

  // Capacity of zero acts as one, anything above the slot count as the slot count.
  always_comb begin
    cap_eff = CW'(capacity);
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (cap_eff > MAX_C) begin
      cap_eff = MAX_C;
    end
  end

  // A new item is taken only while no dump is running.
  assign take     = q_ctl.valid && (remain_r == '0);
  assign q_pop    = take;
  assign miss     = (hit_vec == '0);
  assign load_out = (remain_r != '0) && (!out_valid_r || !out_stall);

  // Lookup, eviction and insertion.
  always_comb begin
    evict    = miss && (cnt_r != '0) && (CW'(cnt_r) >= cap_eff);
    old_new  = evict ? ((old_r == LAST_IX) ? '0 : old_r + IDX_W'(1)) : old_r;
    cnt_keep = evict ? cnt_r - CNT_W'(1) : cnt_r;
    ins_pos  = ring_add(old_new, SW'(cnt_keep));
    cnt_new  = miss ? cnt_keep + CNT_W'(1) : cnt_r;
    newest   = ring_add(old_new, SW'(cnt_new) - SW'(1));
  end

  // Next state of the store, the dump sequencer and the output register.
  always_comb begin
    valid_nxt     = valid_r;
    old_nxt       = old_r;
    cnt_nxt       = cnt_r;
    dump_pos_nxt  = dump_pos_r;
    remain_nxt    = remain_r;
    dump_n_nxt    = dump_n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_key_nxt   = out_key_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    if (take) begin
      if (q_ctl.eos) begin
        // Start a dump from the newest key and clear the store at once.
        dump_pos_nxt = newest;
        remain_nxt   = cnt_new;
        dump_n_nxt   = cnt_new;
        valid_nxt    = '0;
        old_nxt      = '0;
        cnt_nxt      = '0;
      end else begin
        if (evict) begin
          valid_nxt[old_r] = 1'b0;
        end
        if (miss) begin
          valid_nxt[ins_pos] = 1'b1;
        end
        old_nxt = old_new;
        cnt_nxt = cnt_new;
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = slot_r[dump_pos_r];
      out_cnt_nxt   = dump_n_r;
      out_last_nxt  = (remain_r == CNT_W'(1));
      remain_nxt    = remain_r - CNT_W'(1);
      dump_pos_nxt  = (dump_pos_r == '0) ? LAST_IX : dump_pos_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      old_r       <= '0;
      cnt_r       <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      old_r       <= old_nxt;
      cnt_r       <= cnt_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    dump_pos_r <= dump_pos_nxt;
    dump_n_r   <= dump_n_nxt;
    out_key_r  <= out_key_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  // A missed key is written into its slot, also on the last beat of a run.
  always_ff @(posedge clk) begin
    if (take && miss) begin
      slot_r[ins_pos] <= q_key;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_last_entry = out_last_r;

  // Fit the key and the count to the fixed result widths.
  generate
    if (KEY_BITS >= OUT_KEY_W) begin : g_key_cut
      assign out_stored_key = out_key_r[OUT_KEY_W-1:0];
    end else begin : g_key_ext
      assign out_stored_key = {{(OUT_KEY_W-KEY_BITS){1'b0}}, out_key_r};
    end
    if (CNT_W >= COUNT_OUT_W) begin : g_cnt_cut
      assign out_entry_count = out_cnt_r[COUNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign out_entry_count = {{(COUNT_OUT_W-CNT_W){1'b0}}, out_cnt_r};
    end
  endgenerate

endmodule

@@ hdl/fifo_replacement_key_cache_top.sv @@
`timescale 1ns / 1ps

// Fully associative key cache with first-in-first-out replacement.
// Input channel (in_valid / in_stall): one beat carries a key and an
// end-of-sequence flag. Each key is compared against all stored keys at
// once; a miss appends it, evicting the oldest key when the cache is full.
// Keys without end-of-sequence give no result, one beat per cycle sustained
// while no dump runs. A beat with end-of-sequence is looked up first; then
// every stored key is sent on the result channel (out_valid / out_stall)
// from newest to oldest, with the entry count and a last flag on the
// oldest, by way of the dump sequencer and the output register. The dump
// sends one beat per cycle unless stalled, blocking new lookups meanwhile.
// A two-entry queue in front keeps accepting beats while the dump runs.
// When the receiver stalls, the output register and the dump hold, and the
// input stalls once the queue is full. cfg_valid / cfg_ready writes the
// capacity (0 acts as 1, above the slot count as the slot count). The user
// must write it only while the block is idle; the block does not check.
// Reset: empty cache, capacity 32. Each dump also leaves the cache empty.

module fifo_replacement_key_cache_top
  import frkc_pkg::*;
#(
  parameter int MAX_SLOTS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_capacity,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic                   in_end_of_sequence,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_KEY_W-1:0]   out_stored_key,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic                   out_last_entry
);

  logic [CFG_W-1:0]    capacity_r;
  frkc_ctl_t           q_ctl;
  logic [KEY_BITS-1:0] q_key;
  logic                q_pop;

  // Capacity register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_capacity;
    end
  end

  // Front part: input queue.
  frkc_in_queue #(
    .KEY_BITS (KEY_BITS)
  ) u_queue (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key             (in_key),
    .in_end_of_sequence (in_end_of_sequence),
    .q_ctl              (q_ctl),
    .q_key              (q_key),
    .q_pop              (q_pop)
  );

  // Back part: key store, lookup and dump.
  frkc_store #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_store (
    .clk             (clk),
    .rst_n           (rst_n),
    .capacity        (capacity_r),
    .q_ctl           (q_ctl),
    .q_key           (q_key),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_stored_key  (out_stored_key),
    .out_entry_count (out_entry_count),
    .out_last_entry  (out_last_entry)
  );

endmodule
